[hw/rtl/clr_pkg.sv]
// Shared constants for the clipped line rasterizer: command codes and register indexes.
package clr_pkg;

	localparam int unsigned CFG_IDX_BITS = 3;

	localparam logic CMD_START = 1'b0;
	localparam logic CMD_STEP  = 1'b1;

	localparam logic [CFG_IDX_BITS-1:0] CFG_CLIP_LEFT    = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_CLIP_TOP     = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] CFG_CLIP_RIGHT   = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] CFG_CLIP_BOTTOM  = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] CFG_PIXEL_FORMAT = 3'd4;
	localparam logic [CFG_IDX_BITS-1:0] CFG_BLEND_ENABLE = 3'd5;

endpackage

[hw/rtl/clr_if.sv]
// Valid/ready channel interfaces: line command words in, pixel words out.
interface clr_cmd_if #(parameter int unsigned COORD_BITS = 16);
	logic                         valid;
	logic                         ready;
	logic                         cmd;
	logic signed [COORD_BITS-1:0] start_x;
	logic signed [COORD_BITS-1:0] start_y;
	logic signed [COORD_BITS-1:0] end_x;
	logic signed [COORD_BITS-1:0] end_y;

	modport source (output valid, cmd, start_x, start_y, end_x, end_y, input ready);
	modport sink   (input valid, cmd, start_x, start_y, end_x, end_y, output ready);
endinterface

interface clr_pix_if #(parameter int unsigned COORD_BITS = 16);
	logic                         valid;
	logic                         ready;
	logic signed [COORD_BITS-1:0] pixel_x;
	logic signed [COORD_BITS-1:0] pixel_y;
	logic                         draw;
	logic                         blend;
	logic                         last;

	modport source (output valid, pixel_x, pixel_y, draw, blend, last, input ready);
	modport sink   (input valid, pixel_x, pixel_y, draw, blend, last, output ready);
endinterface

[hw/rtl/clipped_line_rasterizer.sv]
// Top level: line setup with span clipping, Bresenham walk and per-pixel clip test.
//
// channel   dir  handshake     word
// cmd_ch    in   valid/ready   cmd, start_x, start_y, end_x, end_y
// pix_ch    out  valid/ready   pixel_x, pixel_y, draw, blend, last
// cfg       in   cfg_we        cfg_index, cfg_data
//
// One word per cycle: a step updates the line state and loads the pixel register
// in the cycle it is accepted; the error-term add and compare set that figure.
// A start word yields no pixel. Reset clears line state to idle and the clip window
// to its reset edges. cmd_ch.ready drops only while a pixel waits unclaimed.
module clipped_line_rasterizer
	import clr_pkg::*;
#(
	parameter int unsigned COORD_BITS = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic [CFG_IDX_BITS-1:0] cfg_index,
	input  logic [COORD_BITS-1:0]   cfg_data,
	clr_cmd_if.sink                 cmd_ch,
	clr_pix_if.source               pix_ch
);

	localparam int unsigned CW = COORD_BITS;
	localparam int unsigned EW = COORD_BITS + 2;
	localparam int unsigned E2W = COORD_BITS + 3;
	localparam logic signed [CW-1:0] COORD_MAX = {1'b0, {(CW-1){1'b1}}};
	localparam logic signed [CW-1:0] ONE = {{(CW-1){1'b0}}, 1'b1};

	typedef enum logic [1:0] {MODE_IDLE, MODE_HLINE, MODE_VLINE, MODE_DIAG} mode_t;

	mode_t                  mode_q;
	logic signed [CW-1:0]   cur_x_q, cur_y_q, tgt_x_q, tgt_y_q;
	logic [CW-1:0]          dist_x_q, dist_y_q;
	logic                   x_neg_q, y_neg_q;
	logic signed [EW-1:0]   err_q;

	logic signed [CW-1:0]   clip_left_q, clip_top_q, clip_right_q, clip_bottom_q;
	logic                   blend_en_q;

	logic                   out_valid_q;
	logic signed [CW-1:0]   pixel_x_q, pixel_y_q;
	logic                   draw_q, blend_q, last_q;

	logic                   acc;

	// start setup
	logic                   horiz, vert;
	logic signed [CW-1:0]   sa, sb, fixed, fix_lo, fix_hi, run_lo, run_hi;
	logic signed [CW-1:0]   span_s, span_e, span_lo, span_hi;
	logic                   span_ok;
	logic signed [CW:0]     diff_x, diff_y;
	logic signed [CW:0]     neg_x, neg_y;
	logic [CW-1:0]          dx, dy;

	// step
	logic signed [CW-1:0]   inc_x, inc_y;
	logic signed [E2W-1:0]  e2, dxe, dye, err_nx;
	logic                   move_x, move_y, at_tgt, in_clip;

	assign acc          = cmd_ch.valid && cmd_ch.ready;
	assign cmd_ch.ready = !out_valid_q || pix_ch.ready;

	always_comb begin
		horiz  = (cmd_ch.start_y == cmd_ch.end_y);
		vert   = (cmd_ch.start_x == cmd_ch.end_x);
		sa     = horiz ? cmd_ch.start_x : cmd_ch.start_y;
		sb     = horiz ? cmd_ch.end_x   : cmd_ch.end_y;
		fixed  = horiz ? cmd_ch.start_y : cmd_ch.start_x;
		fix_lo = horiz ? clip_top_q     : clip_left_q;
		fix_hi = horiz ? clip_bottom_q  : clip_right_q;
		run_lo = horiz ? clip_left_q    : clip_top_q;
		run_hi = horiz ? clip_right_q   : clip_bottom_q;
		span_s = (sa < sb) ? sa : sb;
		span_e = (sa < sb) ? sb : sa;
		span_lo = (span_s < run_lo) ? run_lo : span_s;
		span_hi = (span_e > run_hi) ? run_hi : span_e;
		span_ok = (fixed >= fix_lo) && (fixed < fix_hi) && !(span_e < run_lo)
			&& (span_lo < span_hi);

		diff_x = {cmd_ch.end_x[CW-1], cmd_ch.end_x} - {cmd_ch.start_x[CW-1], cmd_ch.start_x};
		diff_y = {cmd_ch.end_y[CW-1], cmd_ch.end_y} - {cmd_ch.start_y[CW-1], cmd_ch.start_y};
		neg_x  = -diff_x;
		neg_y  = -diff_y;
		dx     = diff_x[CW] ? neg_x[CW-1:0] : diff_x[CW-1:0];
		dy     = diff_y[CW] ? neg_y[CW-1:0] : diff_y[CW-1:0];
	end

	always_comb begin
		inc_x   = cur_x_q + ONE;
		inc_y   = cur_y_q + ONE;
		dxe     = $signed({3'b000, dist_x_q});
		dye     = $signed({3'b000, dist_y_q});
		e2      = {err_q, 1'b0};
		move_x  = (e2 > -dye);
		move_y  = (e2 < dxe);
		err_nx  = {err_q[EW-1], err_q} - (move_x ? dye : '0) + (move_y ? dxe : '0);
		at_tgt  = (cur_x_q == tgt_x_q) && (cur_y_q == tgt_y_q);
		in_clip = (cur_x_q >= clip_left_q) && (cur_y_q >= clip_top_q)
			&& (cur_x_q < clip_right_q) && (cur_y_q < clip_bottom_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clip_left_q   <= '0;
			clip_top_q    <= '0;
			clip_right_q  <= COORD_MAX;
			clip_bottom_q <= COORD_MAX;
			blend_en_q    <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_CLIP_LEFT:    clip_left_q   <= cfg_data;
				CFG_CLIP_TOP:     clip_top_q    <= cfg_data;
				CFG_CLIP_RIGHT:   clip_right_q  <= cfg_data;
				CFG_CLIP_BOTTOM:  clip_bottom_q <= cfg_data;
				CFG_BLEND_ENABLE: blend_en_q    <= cfg_data[0];
				// pixel format only concerns the downstream writer
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MODE_IDLE;
			cur_x_q     <= '0;
			cur_y_q     <= '0;
			tgt_x_q     <= '0;
			tgt_y_q     <= '0;
			dist_x_q    <= '0;
			dist_y_q    <= '0;
			x_neg_q     <= 1'b0;
			y_neg_q     <= 1'b0;
			err_q       <= '0;
			out_valid_q <= 1'b0;
			pixel_x_q   <= '0;
			pixel_y_q   <= '0;
			draw_q      <= 1'b0;
			blend_q     <= 1'b0;
			last_q      <= 1'b0;
		end else begin
			if (pix_ch.ready)
				out_valid_q <= 1'b0;
			if (acc && cmd_ch.cmd == CMD_START) begin
				mode_q <= MODE_IDLE;
				if (horiz || vert) begin
					if (span_ok) begin
						mode_q <= horiz ? MODE_HLINE : MODE_VLINE;
						if (horiz) begin
							cur_x_q <= span_lo;
							tgt_x_q <= span_hi;
							cur_y_q <= cmd_ch.start_y;
							tgt_y_q <= cmd_ch.start_y;
						end else begin
							cur_y_q <= span_lo;
							tgt_y_q <= span_hi;
							cur_x_q <= cmd_ch.start_x;
							tgt_x_q <= cmd_ch.start_x;
						end
					end
				end else begin
					mode_q   <= MODE_DIAG;
					dist_x_q <= dx;
					dist_y_q <= dy;
					x_neg_q  <= !(cmd_ch.start_x < cmd_ch.end_x);
					y_neg_q  <= !(cmd_ch.start_y < cmd_ch.end_y);
					err_q    <= $signed({2'b00, dx}) - $signed({2'b00, dy});
					cur_x_q  <= cmd_ch.start_x;
					cur_y_q  <= cmd_ch.start_y;
					tgt_x_q  <= cmd_ch.end_x;
					tgt_y_q  <= cmd_ch.end_y;
				end
			end else if (acc) begin
				out_valid_q <= 1'b1;
				blend_q     <= blend_en_q;
				pixel_x_q   <= cur_x_q;
				pixel_y_q   <= cur_y_q;
				draw_q      <= 1'b1;
				last_q      <= 1'b0;
				unique case (mode_q)
					MODE_HLINE: begin
						cur_x_q <= inc_x;
						if (inc_x >= tgt_x_q) begin
							last_q <= 1'b1;
							mode_q <= MODE_IDLE;
						end
					end
					MODE_VLINE: begin
						cur_y_q <= inc_y;
						if (inc_y >= tgt_y_q) begin
							last_q <= 1'b1;
							mode_q <= MODE_IDLE;
						end
					end
					MODE_DIAG: begin
						draw_q <= in_clip;
						if (at_tgt) begin
							last_q <= 1'b1;
							mode_q <= MODE_IDLE;
						end else begin
							err_q <= err_nx[EW-1:0];
							if (move_x)
								cur_x_q <= x_neg_q ? cur_x_q - ONE : inc_x;
							if (move_y)
								cur_y_q <= y_neg_q ? cur_y_q - ONE : inc_y;
						end
					end
					default: begin
						pixel_x_q <= '0;
						pixel_y_q <= '0;
						draw_q    <= 1'b0;
						last_q    <= 1'b1;
					end
				endcase
			end
		end
	end

	assign pix_ch.valid   = out_valid_q;
	assign pix_ch.pixel_x = pixel_x_q;
	assign pix_ch.pixel_y = pixel_y_q;
	assign pix_ch.draw    = draw_q;
	assign pix_ch.blend   = blend_q;
	assign pix_ch.last    = last_q;

endmodule

[hw/rtl/clr_checker.sv]
// Port-level checks for the clipped line rasterizer, bound to the top level.
module clr_checker
	import clr_pkg::*;
#(
	parameter int unsigned COORD_BITS = 16
) (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_valid,
	input logic                         in_ready,
	input logic                         in_cmd,
	input logic                         out_valid,
	input logic                         out_ready,
	input logic signed [COORD_BITS-1:0] out_x,
	input logic signed [COORD_BITS-1:0] out_y,
	input logic                         out_draw,
	input logic                         out_last
);

	// every accepted step word yields a pixel word next cycle
	a_step_gives_pixel: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_cmd == CMD_STEP |=> out_valid)
		else $error("step word produced no pixel");

	// a start word never produces a pixel
	a_start_silent: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_cmd == CMD_START && !out_valid |=> !out_valid)
		else $error("start word produced a pixel");

	// no word taken while a pixel is stalled
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("input accepted over a stalled pixel");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_x) && $stable(out_y)
			&& $stable(out_draw) && $stable(out_last))
		else $error("stalled pixel word changed");

endmodule

bind clipped_line_rasterizer clr_checker #(.COORD_BITS(COORD_BITS)) u_clr_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (cmd_ch.valid),
	.in_ready  (cmd_ch.ready),
	.in_cmd    (cmd_ch.cmd),
	.out_valid (pix_ch.valid),
	.out_ready (pix_ch.ready),
	.out_x     (pix_ch.pixel_x),
	.out_y     (pix_ch.pixel_y),
	.out_draw  (pix_ch.draw),
	.out_last  (pix_ch.last)
);
